// ===== sv/bqld_pkg.sv =====
// shared constants and types for the biquad low-pass decimator
`default_nettype none

package bqld_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COEF_WIDTH   = 16;

    localparam int NUM_COEFS     = 5;
    localparam int ADDR_WIDTH    = 5;
    localparam int REG_IDX_WIDTH = 3;
    localparam int DATA_WIDTH    = 32;

    localparam logic [REG_IDX_WIDTH-1:0] REG_A0 = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_A1 = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_A2 = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_B1 = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_B2 = 3'd4;

    localparam logic [DATA_WIDTH-1:0] A0_RESET = 32'd5505;
    localparam logic [DATA_WIDTH-1:0] A1_RESET = 32'd11009;
    localparam logic [DATA_WIDTH-1:0] A2_RESET = 32'd5505;
    localparam logic [DATA_WIDTH-1:0] B1_RESET = 32'd2891;
    localparam logic [DATA_WIDTH-1:0] B2_RESET = 32'd2743;

    typedef struct packed {
        logic advance;
        logic last;
    } step_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/bqld_cfg.sv =====
// coefficient registers behind the apb-style configuration port
`default_nettype none

module bqld_cfg #(
    parameter int COEF_WIDTH = bqld_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          psel,
    input  wire logic                                          penable,
    input  wire logic                                          pwrite,
    input  wire logic [bqld_pkg::ADDR_WIDTH-1:0]               paddr,
    input  wire logic [bqld_pkg::DATA_WIDTH-1:0]               pwdata,
    output logic      [bqld_pkg::DATA_WIDTH-1:0]               prdata,
    output logic      [bqld_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs
);

    logic [bqld_pkg::REG_IDX_WIDTH-1:0] reg_idx;
    logic                               wr_en;
    logic [COEF_WIDTH-1:0]              a0_reg;
    logic [COEF_WIDTH-1:0]              a1_reg;
    logic [COEF_WIDTH-1:0]              a2_reg;
    logic [COEF_WIDTH-1:0]              b1_reg;
    logic [COEF_WIDTH-1:0]              b2_reg;
    logic [COEF_WIDTH-1:0]              wr_data;

    assign reg_idx = paddr[bqld_pkg::ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign wr_data = pwdata[COEF_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg <= bqld_pkg::A0_RESET[COEF_WIDTH-1:0];
            a1_reg <= bqld_pkg::A1_RESET[COEF_WIDTH-1:0];
            a2_reg <= bqld_pkg::A2_RESET[COEF_WIDTH-1:0];
            b1_reg <= bqld_pkg::B1_RESET[COEF_WIDTH-1:0];
            b2_reg <= bqld_pkg::B2_RESET[COEF_WIDTH-1:0];
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bqld_pkg::REG_A0: a0_reg <= wr_data;
                bqld_pkg::REG_A1: a1_reg <= wr_data;
                bqld_pkg::REG_A2: a2_reg <= wr_data;
                bqld_pkg::REG_B1: b1_reg <= wr_data;
                bqld_pkg::REG_B2: b2_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bqld_pkg::REG_A0: prdata = bqld_pkg::DATA_WIDTH'(a0_reg);
            bqld_pkg::REG_A1: prdata = bqld_pkg::DATA_WIDTH'(a1_reg);
            bqld_pkg::REG_A2: prdata = bqld_pkg::DATA_WIDTH'(a2_reg);
            bqld_pkg::REG_B1: prdata = bqld_pkg::DATA_WIDTH'(b1_reg);
            bqld_pkg::REG_B2: prdata = bqld_pkg::DATA_WIDTH'(b2_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        coefs                   = '0;
        coefs[bqld_pkg::REG_A0] = a0_reg;
        coefs[bqld_pkg::REG_A1] = a1_reg;
        coefs[bqld_pkg::REG_A2] = a2_reg;
        coefs[bqld_pkg::REG_B1] = b1_reg;
        coefs[bqld_pkg::REG_B2] = b2_reg;
    end

endmodule

`default_nettype wire

// ===== sv/bqld_filter.sv =====
// biquad arithmetic with history registers and decimation phase
`default_nettype none

module bqld_filter #(
    parameter int SAMPLE_WIDTH = bqld_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = bqld_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic [bqld_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs,
    input  wire logic [SAMPLE_WIDTH-1:0]                       sample,
    input  wire bqld_pkg::step_ctrl_t                          ctrl,
    output logic      [SAMPLE_WIDTH-1:0]                       result,
    output logic                                               odd_phase
);

    localparam int FRAC_BITS = COEF_WIDTH - 2;
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W     = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;

    logic [SAMPLE_WIDTH-1:0] x1_reg;
    logic [SAMPLE_WIDTH-1:0] x2_reg;
    logic [SAMPLE_WIDTH-1:0] y1_reg;
    logic [SAMPLE_WIDTH-1:0] y2_reg;
    logic                    odd_reg;

    logic signed [PROD_W-1:0] p_a0;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;

    assign p_a0 = $signed(coefs[bqld_pkg::REG_A0]) * $signed(sample);
    assign p_a1 = $signed(coefs[bqld_pkg::REG_A1]) * $signed(x1_reg);
    assign p_a2 = $signed(coefs[bqld_pkg::REG_A2]) * $signed(x2_reg);
    assign p_b1 = $signed(coefs[bqld_pkg::REG_B1]) * $signed(y1_reg);
    assign p_b2 = $signed(coefs[bqld_pkg::REG_B2]) * $signed(y2_reg);

    assign acc = ACC_W'(p_a0) + ACC_W'(p_a1) + ACC_W'(p_a2)
               - ACC_W'(p_b1) - ACC_W'(p_b2)
               + (ACC_W'(1) <<< (FRAC_BITS - 1));

    assign shifted = acc >>> FRAC_BITS;

    // all bits above the result sign must match it
    assign fits = (&shifted[ACC_W-1:SAMPLE_WIDTH-1]) || !(|shifted[ACC_W-1:SAMPLE_WIDTH-1]);

    always_comb
    begin
        if (fits)
        begin
            result = shifted[SAMPLE_WIDTH-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    assign odd_phase = odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            y1_reg  <= '0;
            y2_reg  <= '0;
            odd_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            if (ctrl.last)
            begin
                x1_reg  <= '0;
                x2_reg  <= '0;
                y1_reg  <= '0;
                y2_reg  <= '0;
                odd_reg <= 1'b0;
            end
            else
            begin
                x1_reg  <= sample;
                x2_reg  <= x1_reg;
                y1_reg  <= result;
                y2_reg  <= y1_reg;
                odd_reg <= !odd_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/biquad_lowpass_decimate_by_two_unit.sv =====
// top level: input register, biquad step, decimating result register
// an accepted item waits in the input register until the biquad step advances, and an
// emitted result is held in the output register until taken; the biquad feedback path
// limits throughput to one item per cycle, and a full output stalls emitting steps
// reset: coefficients return to their defaults, histories and phase clear to zero
`default_nettype none

module biquad_lowpass_decimate_by_two_unit #(
    parameter int SAMPLE_WIDTH = bqld_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = bqld_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bqld_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bqld_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [bqld_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]           sample_in,
    input  wire logic                              last_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [SAMPLE_WIDTH-1:0]           filtered_sample
);

    logic [bqld_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                    s1_last_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_data_reg;
    logic [SAMPLE_WIDTH-1:0] step_result;
    logic                    odd_phase;
    logic                    out_free;
    logic                    emit;
    logic                    in_fire;
    bqld_pkg::step_ctrl_t    step;

    assign pready = 1'b1;

    bqld_cfg #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coefs   (coefs)
    );

    bqld_filter #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .coefs     (coefs),
        .sample    (s1_sample_reg),
        .ctrl      (step),
        .result    (step_result),
        .odd_phase (odd_phase)
    );

    assign out_free     = !out_valid_reg || out_ready;
    assign emit         = !odd_phase;
    assign step.advance = s1_valid_reg && (odd_phase || out_free);
    assign step.last    = s1_last_reg;
    assign in_ready     = !s1_valid_reg || step.advance;
    assign in_fire      = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !step.advance);
    assign out_valid_next = (out_valid_reg && !out_ready) || (step.advance && emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= sample_in;
            s1_last_reg   <= last_sample;
        end
        if (step.advance && emit)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        step.advance && emit |=> out_valid_reg)
        else $error("emitted step did not produce a result");

    a_last_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step.advance && step.last |=> !odd_phase)
        else $error("phase not cleared after last sample");

    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        step.advance && !step.last |=> odd_phase != $past(odd_phase))
        else $error("phase did not toggle on a step");

    a_stalled_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step.advance |-> !in_ready)
        else $error("input taken while stage holds a stalled item");

endmodule

`default_nettype wire

// ===== verif/tb_biquad_lowpass_decimate_by_two_unit.sv =====
// testbench for the biquad low-pass decimate-by-two unit: directed and random items vs. a predictor
module tb_biquad_lowpass_decimate_by_two_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bqld_pkg::*;

    localparam int SW = DEF_SAMPLE_WIDTH;
    localparam int CW = DEF_COEF_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_SETTLE = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [SW-1:0]         sample_in;
    logic                  last_sample;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SW-1:0]         filtered_sample;

    // filter state as the block should hold it
    logic signed [CW-1:0] coef_q [NUM_COEFS];
    logic signed [SW-1:0] x_prev1, x_prev2, y_prev1, y_prev2;
    logic                 skip_next;
    logic signed [SW-1:0] expected_outputs [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    logic        gaps_on = 1'b1;
    logic        rx_full_speed = 1'b0;
    logic [15:0] stall_pattern = 16'hb5a7;

    biquad_lowpass_decimate_by_two_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_in       (sample_in),
        .last_sample     (last_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls on a rotating pattern, periodically reloaded with a random value
    always @(posedge clk)
    begin
        if (cycle_count[5:0] == 6'd0)
            stall_pattern <= 16'($urandom) | 16'h0101;
        else
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        out_ready <= rx_full_speed | stall_pattern[0];
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 200)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic longint tap(input logic signed [CW-1:0] c,
                                   input logic signed [SW-1:0] s);
        longint lc, ls;
        lc = c;
        ls = s;
        return lc * ls;
    endfunction

    function automatic logic signed [SW-1:0] biquad_output(input logic signed [SW-1:0] x);
        longint acc, hi, lo;
        acc = tap(coef_q[REG_A0], x) + tap(coef_q[REG_A1], x_prev1)
            + tap(coef_q[REG_A2], x_prev2)
            - tap(coef_q[REG_B1], y_prev1) - tap(coef_q[REG_B2], y_prev2);
        acc = acc + (longint'(1) <<< (CW - 3));
        acc = acc >>> (CW - 2);
        hi = S_MAX;
        lo = S_MIN;
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        return SW'(acc);
    endfunction

    task automatic clear_history;
        x_prev1 = '0;
        x_prev2 = '0;
        y_prev1 = '0;
        y_prev2 = '0;
        skip_next = 1'b0;
    endtask

    task automatic filter_accept(input logic signed [SW-1:0] x, input logic last);
        logic signed [SW-1:0] y;
        y = biquad_output(x);
        if (!skip_next)
            expected_outputs.push_back(y);
        x_prev2 = x_prev1;
        x_prev1 = x;
        y_prev2 = y_prev1;
        y_prev1 = y;
        skip_next = ~skip_next;
        if (last)
            clear_history();
    endtask

    always @(posedge clk)
    begin : monitor
        logic signed [SW-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                filter_accept(sample_in, last_sample);
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch($sformatf("unexpected item %0d", $signed(filtered_sample)));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (filtered_sample !== want)
                        report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                                                  $signed(filtered_sample), want));
                end
            end
        end
    end

    task automatic write_coef(input int unsigned idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_COEFS)
            coef_q[idx] = value[CW-1:0];
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic signed [CW-1:0] a0, input logic signed [CW-1:0] a1,
                              input logic signed [CW-1:0] a2, input logic signed [CW-1:0] b1,
                              input logic signed [CW-1:0] b2);
        write_coef(REG_A0, {{(DATA_WIDTH-CW){a0[CW-1]}}, a0});
        write_coef(REG_A1, {{(DATA_WIDTH-CW){a1[CW-1]}}, a1});
        write_coef(REG_A2, {{(DATA_WIDTH-CW){a2[CW-1]}}, a2});
        write_coef(REG_B1, {{(DATA_WIDTH-CW){b1[CW-1]}}, b1});
        write_coef(REG_B2, {{(DATA_WIDTH-CW){b2[CW-1]}}, b2});
    endtask

    task automatic load_default_coefs;
        write_coef(REG_A0, A0_RESET);
        write_coef(REG_A1, A1_RESET);
        write_coef(REG_A2, A2_RESET);
        write_coef(REG_B1, B1_RESET);
        write_coef(REG_B2, B2_RESET);
    endtask

    task automatic send_sample(input logic signed [SW-1:0] x, input logic last);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid    <= 1'b1;
        sample_in   <= x;
        last_sample <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_until_idle;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1: return SW'($signed($urandom_range(0, 32)) - 16);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic test_default_coefs;
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(16'sd1, 1'b0);
        // last item on an emitting phase
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd0, 1'b0);
        // last item on a silent phase
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd7, 1'b0);
        wait_until_idle();
    endtask

    task automatic test_saturation;
        load_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b1);
        wait_until_idle();
        load_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_unmapped_regs;
        load_default_coefs();
        write_coef(NUM_COEFS, 32'h7fff_8000);
        write_coef(6, 32'hffff_ffff);
        write_coef(7, 32'h0000_0000);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd12345, 1'b0);
        send_sample(16'sd0, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_random_streams;
        int sent, len;
        logic last;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: load_default_coefs();
                1: load_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
                2: load_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
                default:
                    for (int r = 0; r < NUM_COEFS; r++)
                        write_coef(r, $urandom);
            endcase
            gaps_on = (phase % 3) != 2;
            rx_full_speed <= (phase % 4) == 1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len && sent < PHASE_ITEMS; i++)
                begin
                    last = (i == len - 1) || ($urandom_range(0, 15) == 0);
                    send_sample(rand_sample(), last);
                    sent++;
                    // hold off until the block has drained
                    if (phase == 4 && sent == PHASE_ITEMS / 2)
                        wait_until_idle();
                end
            end
            wait_until_idle();
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        sample_in   <= '0;
        last_sample <= 1'b0;
        coef_q[REG_A0] = A0_RESET[CW-1:0];
        coef_q[REG_A1] = A1_RESET[CW-1:0];
        coef_q[REG_A2] = A2_RESET[CW-1:0];
        coef_q[REG_B1] = B1_RESET[CW-1:0];
        coef_q[REG_B2] = B2_RESET[CW-1:0];
        clear_history();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_coefs();
        test_saturation();
        test_unmapped_regs();
        test_random_streams();

        wait_until_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
